[src/rds_pkg.sv]
// Package for the recovery deploy sequencer: payload structs, config struct,
// register indexes and reset values. No dependencies.
package rds_pkg;

   localparam int DutyWidth  = 14;
   localparam int CountWidth = 10;
   localparam int TimerWidth = 16;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   // Register reset values
   localparam logic [DutyWidth-1:0]  LeftInitReset   = 14'd725;
   localparam logic [DutyWidth-1:0]  LeftEndReset    = 14'd930;
   localparam logic [DutyWidth-1:0]  RightInitReset  = 14'd960;
   localparam logic [DutyWidth-1:0]  RightEndReset   = 14'd790;
   localparam logic [CountWidth-1:0] DebounceReset   = 10'd100;
   localparam logic [TimerWidth-1:0] PulseReset      = 16'd2000;
   localparam logic [TimerWidth-1:0] HoldReset       = 16'd40000;

   // Saturation limit of the debounce counters
   localparam logic [CountWidth-1:0] CountMax = '1;

   // Register indexes on the csr port
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LEFT_INIT  = 3'd0,
      CSR_LEFT_END   = 3'd1,
      CSR_RIGHT_INIT = 3'd2,
      CSR_RIGHT_END  = 3'd3,
      CSR_DEBOUNCE   = 3'd4,
      CSR_PULSE      = 3'd5,
      CSR_HOLD       = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic drogue_cmd;
      logic main_cmd;
      logic reset_level;
   } req_type;

   typedef struct packed {
      logic [DutyWidth-1:0] left_duty;
      logic [DutyWidth-1:0] right_duty;
      logic                 drogue_ack;
      logic                 main_ack;
      logic                 bridge_on;
   } rsp_type;

   typedef struct packed {
      logic [DutyWidth-1:0]  left_init_duty;
      logic [DutyWidth-1:0]  left_end_duty;
      logic [DutyWidth-1:0]  right_init_duty;
      logic [DutyWidth-1:0]  right_end_duty;
      logic [CountWidth-1:0] debounce_ticks;
      logic [TimerWidth-1:0] pulse_ticks;
      logic [TimerWidth-1:0] hold_ticks;
   } cfg_type;

endpackage

[src/rds_csr.sv]
// Configuration register file of the recovery deploy sequencer.
// Depends on rds_pkg.
module rds_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rds_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [rds_pkg::CsrDataWidth-1:0]   csr_data,
   output rds_pkg::cfg_type                   cfg
);
   import rds_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   // Register decode; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_LEFT_INIT:  cfg_in.left_init_duty  = csr_data[DutyWidth-1:0];
            CSR_LEFT_END:   cfg_in.left_end_duty   = csr_data[DutyWidth-1:0];
            CSR_RIGHT_INIT: cfg_in.right_init_duty = csr_data[DutyWidth-1:0];
            CSR_RIGHT_END:  cfg_in.right_end_duty  = csr_data[DutyWidth-1:0];
            CSR_DEBOUNCE:   cfg_in.debounce_ticks  = csr_data[CountWidth-1:0];
            CSR_PULSE:      cfg_in.pulse_ticks     = csr_data[TimerWidth-1:0];
            CSR_HOLD:       cfg_in.hold_ticks      = csr_data[TimerWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_init_duty  <= LeftInitReset;
         cfg_ff.left_end_duty   <= LeftEndReset;
         cfg_ff.right_init_duty <= RightInitReset;
         cfg_ff.right_end_duty  <= RightEndReset;
         cfg_ff.debounce_ticks  <= DebounceReset;
         cfg_ff.pulse_ticks     <= PulseReset;
         cfg_ff.hold_ticks      <= HoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[src/rds_step.sv]
// Per-tick sequencer state and its single-pass update logic.
// Depends on rds_pkg.
module rds_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rds_pkg::req_type req,
   input  rds_pkg::cfg_type cfg,
   output rds_pkg::rsp_type result
);
   import rds_pkg::*;

   logic [CountWidth-1:0] drogue_count_ff, drogue_count_in;
   logic [CountWidth-1:0] main_count_ff, main_count_in;
   logic                  drogue_armed_ff, drogue_armed_in;
   logic                  main_armed_ff, main_armed_in;
   logic                  drogue_ack_ff, drogue_ack_in;
   logic                  main_ack_ff, main_ack_in;
   logic [TimerWidth-1:0] bridge_timer_ff, bridge_timer_in;
   logic [TimerWidth-1:0] hold_timer_ff, hold_timer_in;
   logic                  rest_done_ff, rest_done_in;
   logic                  reset_prev_ff;
   logic [DutyWidth-1:0]  left_duty_ff, left_duty_in;
   logic [DutyWidth-1:0]  right_duty_ff, right_duty_in;

   logic                  rising;
   logic [DutyWidth:0]    left_sum, right_sum;

   assign rising    = req.reset_level && !reset_prev_ff;
   assign left_sum  = {1'b0, cfg.left_init_duty} + {1'b0, cfg.left_end_duty};
   assign right_sum = {1'b0, cfg.right_init_duty} + {1'b0, cfg.right_end_duty};

   // Next state for one tick
   always_comb begin
      drogue_count_in = drogue_count_ff;
      main_count_in   = main_count_ff;
      drogue_armed_in = drogue_armed_ff;
      main_armed_in   = main_armed_ff;
      drogue_ack_in   = drogue_ack_ff;
      main_ack_in     = main_ack_ff;
      hold_timer_in   = hold_timer_ff;
      rest_done_in    = rest_done_ff;
      left_duty_in    = left_duty_ff;
      right_duty_in   = right_duty_ff;

      // bridge pulse counts down every tick
      if (bridge_timer_ff != '0) begin
         bridge_timer_in = bridge_timer_ff - 1'b1;
      end else begin
         bridge_timer_in = bridge_timer_ff;
      end

      if (rising) begin
         // reset edge wins over everything else this tick
         drogue_count_in = '0;
         main_count_in   = '0;
         drogue_armed_in = 1'b0;
         main_armed_in   = 1'b0;
         drogue_ack_in   = 1'b0;
         main_ack_in     = 1'b0;
         bridge_timer_in = '0;
         hold_timer_in   = '0;
         rest_done_in    = 1'b0;
         left_duty_in    = cfg.left_init_duty;
         right_duty_in   = cfg.right_init_duty;
      end else begin
         // drogue debounce
         if (!drogue_armed_ff) begin
            if (!req.drogue_cmd) begin
               drogue_count_in = '0;
            end else begin
               if (drogue_count_ff != CountMax) begin
                  drogue_count_in = drogue_count_ff + 1'b1;
               end
               if (drogue_count_in >= cfg.debounce_ticks) begin
                  drogue_armed_in = 1'b1;
               end
            end
         end
         // main debounce
         if (!main_armed_ff) begin
            if (!req.main_cmd) begin
               main_count_in = '0;
            end else begin
               if (main_count_ff != CountMax) begin
                  main_count_in = main_count_ff + 1'b1;
               end
               if (main_count_in >= cfg.debounce_ticks) begin
                  main_armed_in = 1'b1;
               end
            end
         end
         // drogue release: servos to end positions
         if (drogue_armed_in && !drogue_ack_ff) begin
            drogue_ack_in = 1'b1;
            left_duty_in  = cfg.left_end_duty;
            right_duty_in = cfg.right_end_duty;
         end
         // main release: start bridge pulse
         if (main_armed_in && !main_ack_ff) begin
            main_ack_in     = 1'b1;
            bridge_timer_in = cfg.pulse_ticks;
         end
         // hold, then servos to rest once
         if (drogue_ack_in && main_ack_in && !rest_done_ff) begin
            if (hold_timer_ff >= cfg.hold_ticks) begin
               left_duty_in    = left_sum[DutyWidth:1];
               right_duty_in   = right_sum[DutyWidth:1];
               bridge_timer_in = '0;
               rest_done_in    = 1'b1;
            end else begin
               hold_timer_in = hold_timer_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drogue_count_ff <= '0;
         main_count_ff   <= '0;
         drogue_armed_ff <= 1'b0;
         main_armed_ff   <= 1'b0;
         drogue_ack_ff   <= 1'b0;
         main_ack_ff     <= 1'b0;
         bridge_timer_ff <= '0;
         hold_timer_ff   <= '0;
         rest_done_ff    <= 1'b0;
         reset_prev_ff   <= 1'b0;
         left_duty_ff    <= LeftInitReset;
         right_duty_ff   <= RightInitReset;
      end else if (accept) begin
         drogue_count_ff <= drogue_count_in;
         main_count_ff   <= main_count_in;
         drogue_armed_ff <= drogue_armed_in;
         main_armed_ff   <= main_armed_in;
         drogue_ack_ff   <= drogue_ack_in;
         main_ack_ff     <= main_ack_in;
         bridge_timer_ff <= bridge_timer_in;
         hold_timer_ff   <= hold_timer_in;
         rest_done_ff    <= rest_done_in;
         reset_prev_ff   <= req.reset_level;
         left_duty_ff    <= left_duty_in;
         right_duty_ff   <= right_duty_in;
      end
   end

   // Result word for this tick, from the next state
   always_comb begin
      result.left_duty  = left_duty_in;
      result.right_duty = right_duty_in;
      result.drogue_ack = drogue_ack_in;
      result.main_ack   = main_ack_in;
      result.bridge_on  = (bridge_timer_in != '0);
   end

endmodule

[src/rds_out_buf.sv]
// Two-entry result buffer: output register plus skid entry.
// Depends on rds_pkg.
module rds_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rds_pkg::rsp_type push_data,
   output logic             full,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rds_pkg::rsp_type rsp_data
);
   import rds_pkg::*;

   rsp_type     head_ff, head_in;
   rsp_type     skid_ff, skid_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;

   // Queue update
   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      if (push && pop) begin
         if (count_ff == 2'd1) begin
            head_in = push_data;
         end else begin
            head_in = skid_ff;
            skid_in = push_data;
         end
      end else if (pop) begin
         head_in  = skid_ff;
         count_in = count_ff - 2'd1;
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            skid_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

[src/recovery_deploy_sequencer_top.sv]
// Top level of the recovery deploy sequencer.
// Depends on rds_pkg, rds_csr, rds_step and rds_out_buf.
//
// Usage:
//   One req word per millisecond tick carries the drogue and main command pin
//   levels and the reset pin level. It is taken at a clock edge with req_valid
//   high and req_stall low. Each tick gives exactly one rsp word: servo duties,
//   both acks and the H-bridge drive, as they stand after that tick.
//   A taken word is updated in one pass of compare and count logic from the
//   state registers; its rsp word is registered in the buffer, which drives
//   rsp_data. Throughput is one word per cycle while req_stall is low.
//   The result side has a two-entry buffer, so input keeps flowing while one
//   result waits; req_stall rises only when both entries are held by a
//   stalled receiver, and drops as soon as one is taken.
//   The user writes config registers on the csr channel (csr_ready is always
//   high) only while the block is idle, which it does not enforce; indexes
//   past the list are ignored. Synchronous reset restores register defaults,
//   clears the sequence, sets default init servo duties, empties the buffer.
module recovery_deploy_sequencer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rds_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rds_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rds_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [rds_pkg::CsrDataWidth-1:0]   csr_data
);
   import rds_pkg::*;

   cfg_type cfg;
   rsp_type step_result;
   logic    buf_full;
   logic    accept;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // Configuration registers
   rds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Tick state update
   rds_step u_step (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .result (step_result)
   );

   // Result buffer
   rds_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
